[hw/rtl/jac_pkg.sv]
// Shared constants and types for the joystick axis conditioner.
package jac_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int AVG_DEPTH   = 5;
  localparam int AXIS_COUNT  = 2;

  localparam int AXIS_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam int POS_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W  = SAMPLE_BITS + POS_W;

  localparam int CENTRE         = 2047;
  localparam int FULL_SCALE     = 255;
  localparam int DEADZONE_RESET = 30;
  localparam logic [7:0] SYNC_BYTE = 8'hFF;

  // floor(sum / AVG_DEPTH) as (sum * AVG_RECIP) >> AVG_SHIFT, exact for sum < 2^18
  localparam int AVG_RECIP_W = 16;
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = 16'd52429;
  localparam int AVG_SHIFT = 18;

  // floor(mag / CENTRE) as (mag * SCALE_RECIP) >> SCALE_SHIFT, exact for mag < 599520
  localparam int MAG_W         = 20;
  localparam int SCALE_RECIP_W = 20;
  localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP = 20'd524545;
  localparam int SCALE_SHIFT = 30;
  localparam int Q_W         = 9;

  localparam int VALUE_W    = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic [AXIS_W-1:0]  axis;
    logic [VALUE_W-1:0] value;
  } frame_t;

  typedef enum logic [1:0] {
    SEL_SYNC = 2'd0,
    SEL_AXIS = 2'd1,
    SEL_LO   = 2'd2,
    SEL_HI   = 2'd3
  } byte_sel_t;

endpackage

[hw/rtl/jac_front.sv]
// Front end: sample transfer, per-axis ring and running sum, scaling pipeline, deadzone drop.
module jac_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [jac_pkg::AXIS_W-1:0]    in_axis,
  input  logic [jac_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                          cfg_we,
  input  logic [7:0]                    cfg_wdata,
  input  logic                          q_full,
  output logic                          q_push,
  output jac_pkg::frame_t               q_data
);

  logic [jac_pkg::SAMPLE_BITS-1:0] ring_r [jac_pkg::AXIS_COUNT][jac_pkg::AVG_DEPTH];
  logic [jac_pkg::POS_W-1:0]       pos_r  [jac_pkg::AXIS_COUNT];
  logic [jac_pkg::SUM_W-1:0]       sum_r  [jac_pkg::AXIS_COUNT];
  logic [7:0]                      deadzone_r;

  logic                            adv;
  logic                            take;
  logic [jac_pkg::SAMPLE_BITS-1:0] old_sample;
  logic [jac_pkg::SUM_W-1:0]       sum_nxt;
  logic [jac_pkg::POS_W-1:0]       pos_nxt;

  // pipeline registers
  logic                               s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic [jac_pkg::AXIS_W-1:0]         s1_axis_r, s2_axis_r, s3_axis_r, s4_axis_r;
  logic [jac_pkg::SUM_W-1:0]          s1_sum_r;
  logic [jac_pkg::SAMPLE_BITS-1:0]    s2_avg_r;
  logic                               s3_neg_r, s4_neg_r;
  logic [jac_pkg::MAG_W-1:0]          s3_mag_r;
  logic [jac_pkg::Q_W-1:0]            s4_q_r;

  logic [jac_pkg::SUM_W+jac_pkg::AVG_RECIP_W-1:0]   avg_prod;
  logic signed [jac_pkg::SAMPLE_BITS:0]             centred;
  logic [jac_pkg::SAMPLE_BITS-1:0]                  centred_abs;
  logic [jac_pkg::MAG_W+jac_pkg::SCALE_RECIP_W-1:0] scale_prod;
  logic [jac_pkg::VALUE_W-1:0]                      q_ext;

  // the whole pipeline holds while the queue is full
  assign adv      = !q_full;
  assign in_ready = adv;
  assign take     = in_valid && adv;

  assign old_sample = ring_r[in_axis][pos_r[in_axis]];
  assign sum_nxt    = sum_r[in_axis] - jac_pkg::SUM_W'(old_sample)
                    + jac_pkg::SUM_W'(in_sample);
  assign pos_nxt    = (pos_r[in_axis] == jac_pkg::POS_W'(jac_pkg::AVG_DEPTH - 1))
                    ? '0 : pos_r[in_axis] + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < jac_pkg::AXIS_COUNT; a++) begin
        pos_r[a] <= '0;
        sum_r[a] <= '0;
        for (int i = 0; i < jac_pkg::AVG_DEPTH; i++) begin
          ring_r[a][i] <= '0;
        end
      end
    end else if (take) begin
      ring_r[in_axis][pos_r[in_axis]] <= in_sample;
      pos_r[in_axis]                  <= pos_nxt;
      sum_r[in_axis]                  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r <= 8'(jac_pkg::DEADZONE_RESET);
    end else if (cfg_we) begin
      deadzone_r <= cfg_wdata;
    end
  end

  assign avg_prod    = s1_sum_r * jac_pkg::AVG_RECIP;
  assign centred     = $signed({1'b0, s2_avg_r}) - (jac_pkg::SAMPLE_BITS+1)'(jac_pkg::CENTRE);
  assign centred_abs = centred[jac_pkg::SAMPLE_BITS] ?
                       jac_pkg::SAMPLE_BITS'(-centred) : jac_pkg::SAMPLE_BITS'(centred);
  assign scale_prod  = s3_mag_r * jac_pkg::SCALE_RECIP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_axis_r <= in_axis;
      s1_sum_r  <= sum_nxt;
      s2_axis_r <= s1_axis_r;
      s2_avg_r  <= avg_prod[jac_pkg::AVG_SHIFT +: jac_pkg::SAMPLE_BITS];
      s3_axis_r <= s2_axis_r;
      s3_neg_r  <= centred[jac_pkg::SAMPLE_BITS];
      // times FULL_SCALE as shift and subtract
      s3_mag_r  <= (jac_pkg::MAG_W'(centred_abs) << 8) - jac_pkg::MAG_W'(centred_abs);
      s4_axis_r <= s3_axis_r;
      s4_neg_r  <= s3_neg_r;
      s4_q_r    <= scale_prod[jac_pkg::SCALE_SHIFT +: jac_pkg::Q_W];
    end
  end

  // magnitude never exceeds FULL_SCALE, so the clamp is implicit; drop the deadzone
  assign q_ext        = jac_pkg::VALUE_W'(s4_q_r);
  assign q_push       = adv && s4_valid_r && (s4_q_r > jac_pkg::Q_W'(deadzone_r));
  assign q_data.axis  = s4_axis_r;
  assign q_data.value = s4_neg_r ? (jac_pkg::VALUE_W'(0) - q_ext) : q_ext;

endmodule

[hw/rtl/jac_fifo.sv]
// Short frame queue between the front end and the byte framer.
module jac_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  jac_pkg::frame_t push_data,
  input  logic            pop,
  output jac_pkg::frame_t pop_data,
  output logic            full,
  output logic            not_empty
);

  jac_pkg::frame_t                mem [jac_pkg::FIFO_DEPTH];
  logic [jac_pkg::FIFO_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [jac_pkg::FIFO_AW:0]      count_r;

  assign full      = (count_r == (jac_pkg::FIFO_AW+1)'(jac_pkg::FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("frame queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("frame queue read while empty");
`endif

endmodule

[hw/rtl/jac_back.sv]
// Back end: turns queued values into four-byte frames on the output stream.
module jac_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_not_empty,
  input  jac_pkg::frame_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic                busy_r, busy_nxt;
  jac_pkg::byte_sel_t  sel_r, sel_nxt;
  jac_pkg::frame_t     frame_r;
  logic                xfer;

  assign xfer      = busy_r && out_ready;
  assign q_pop     = q_not_empty && (!busy_r || (xfer && sel_r == jac_pkg::SEL_HI));
  assign out_valid = busy_r;
  assign out_last  = busy_r && (sel_r == jac_pkg::SEL_HI);

  always_comb begin
    busy_nxt = busy_r;
    sel_nxt  = sel_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      sel_nxt  = jac_pkg::SEL_SYNC;
    end else if (xfer) begin
      if (sel_r == jac_pkg::SEL_HI) begin
        busy_nxt = 1'b0;
      end else begin
        sel_nxt = jac_pkg::byte_sel_t'(sel_r + 2'd1);
      end
    end
  end

  always_comb begin
    unique case (sel_r)
      jac_pkg::SEL_SYNC: out_byte = jac_pkg::SYNC_BYTE;
      jac_pkg::SEL_AXIS: out_byte = 8'(frame_r.axis);
      jac_pkg::SEL_LO:   out_byte = frame_r.value[7:0];
      jac_pkg::SEL_HI:   out_byte = frame_r.value[15:8];
      default:           out_byte = jac_pkg::SYNC_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sel_r  <= jac_pkg::SEL_SYNC;
    end else begin
      busy_r <= busy_nxt;
      sel_r  <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      frame_r <= q_data;
    end
  end

`ifndef SYNTH
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && sel_r != jac_pkg::SEL_HI) |=> (busy_r && sel_r == $past(sel_r) + 2'd1))
    else $error("frame byte select did not advance");
  a_start_sync: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (busy_r && sel_r == jac_pkg::SEL_SYNC))
    else $error("new frame did not start on the sync byte");
`endif

endmodule

[hw/rtl/joystick_axis_conditioner_core.sv]
// Joystick axis conditioner: averages, centres, scales and frames joystick samples.
//
// Input stream: in_tdata[11:0] is the raw sample, in_tuser the axis (0 x, 1 y).
// Each sample is stored in its axis's five-entry ring; the ring mean is centred,
// scaled to +-255 and dropped if within the deadzone (cfg_we / cfg_wdata, reset 30).
// A kept value leaves as four bytes on out_tdata: 0xFF, axis, value low, value high
// (16-bit two's complement), with out_tlast on the fourth byte.
// An input transfer reaches the first byte of its frame through the four-stage
// scaling pipeline, the queue write and the framer load.
// Throughput: one sample per cycle while samples fall in the deadzone and the
// queue has room; frames go out at one byte per cycle while out_tready is high,
// and the single output byte lane sets the rate when every sample yields a frame.
// A four-entry queue parts the pipeline from the framer; when the receiver stalls
// the framer holds its byte, the queue fills and in_tready falls, holding the
// whole pipeline. Reset clears both rings, their indexes and the queue, and
// returns the deadzone to 30.
module joystick_axis_conditioner_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] sample, [15:12] zero
  input  logic        in_tuser,   // [0] axis
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_not_empty;
  jac_pkg::frame_t q_wr_data;
  jac_pkg::frame_t q_rd_data;

  jac_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_axis   (in_tuser),
    .in_sample (in_tdata[jac_pkg::SAMPLE_BITS-1:0]),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  jac_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_data),
    .pop       (q_pop),
    .pop_data  (q_rd_data),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  jac_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_rd_data),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_byte    (out_tdata),
    .out_last    (out_tlast)
  );

endmodule
